/* rtl/humidity_temp_frame_decoder_defines.svh */
// Assertion macros shared by the frame decoder checker.
`ifndef HUMIDITY_TEMP_FRAME_DECODER_DEFINES_SVH
`define HUMIDITY_TEMP_FRAME_DECODER_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define HTFD_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("htfd assertion failed");

// Delayed implication from the antecedent to the consequent, disabled while reset is low.
`define HTFD_ASSERT_AFTER3(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> ##3 (cons)) \
        else $error("htfd assertion failed");

`endif

/* rtl/htfd_pkg.sv */
// Package with the types, constants and CRC function of the frame decoder.
package htfd_pkg;

    localparam logic [7:0] POLY_RESET = 8'h31;
    localparam logic [7:0] CRC_INIT   = 8'h00;

    // Conversion constants in hundredths.
    localparam logic signed [15:0] RH_OFFSET = -16'sd600;
    localparam logic signed [15:0] T_OFFSET  = -16'sd4685;
    localparam logic [14:0]        RH_SCALE  = 15'd12500;
    localparam logic [14:0]        T_SCALE   = 15'd17572;

    // Result of the CRC front end, aligned with the end of stage two.
    typedef struct packed {
        logic        valid;
        logic        crc_ok;
        logic        is_hum;
        logic [15:0] raw_code;
    } t_crc_res;

    // One byte of an MSB-first CRC-8.
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in,
                                             input logic [7:0] data,
                                             input logic [7:0] poly);
        logic [7:0] c;
        c = crc_in ^ data;
        for (int k = 0; k < 8; k++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ poly) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

/* rtl/humidity_temp_frame_decoder.sv */
// Top level of the humidity and temperature frame decoder.
//
// One frame (high byte, low byte, check byte) is taken as a beat at each rising
// edge where start is high and busy is low. Busy is held low, so a new frame
// can be given in every cycle.
// Each frame yields one result beat: o_strobe is high for exactly one cycle
// with o_crc_ok, o_is_humidity, o_value_centi and o_raw_code. The result
// passes through the pipeline registers: the CRC runs over two stages
// of one byte each, the conversion over a multiply stage and an offset stage,
// and a last stage applies the CRC verdict. Throughput is one frame per cycle.
// On a CRC mismatch o_crc_ok is low and o_value_centi is zero, while
// o_is_humidity and o_raw_code still report the received code.
// The polynomial register is written by i_cfg_we and i_cfg_wdata; write it
// only while no frame is in flight.
// A synchronous reset empties the pipeline and loads polynomial 0x31.
// The receiver cannot stall; every result must be taken when it is shown.
module humidity_temp_frame_decoder #(
    parameter int FRAME_BYTES = 2
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [7:0]         i_high_byte,
    input  logic [7:0]         i_low_byte,
    input  logic [7:0]         i_check_byte,
    input  logic               i_cfg_we,
    input  logic [7:0]         i_cfg_wdata,
    output logic               o_strobe,
    output logic               o_crc_ok,
    output logic               o_is_humidity,
    output logic signed [14:0] o_value_centi,
    output logic [15:0]        o_raw_code
);

    logic [7:0]         r_poly;
    logic               r_out_valid;
    logic               r_crc_ok;
    logic               r_is_hum;
    logic signed [14:0] r_value;
    logic [15:0]        r_raw;

    htfd_pkg::t_crc_res crc_res;
    logic signed [14:0] conv_value;
    logic               in_beat;

    assign busy    = 1'b0;
    assign in_beat = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poly <= htfd_pkg::POLY_RESET;
        end else if (i_cfg_we) begin
            r_poly <= i_cfg_wdata;
        end
    end

    htfd_crc #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_crc (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (in_beat),
        .i_poly       (r_poly),
        .i_high_byte  (i_high_byte),
        .i_low_byte   (i_low_byte),
        .i_check_byte (i_check_byte),
        .o_res        (crc_res)
    );

    htfd_conv u_conv (
        .i_clk   (i_clk),
        .i_code  ({i_high_byte, i_low_byte}),
        .o_value (conv_value)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= crc_res.valid;
        end
        r_crc_ok <= crc_res.crc_ok;
        r_is_hum <= crc_res.is_hum;
        r_raw    <= crc_res.raw_code;
        r_value  <= crc_res.crc_ok ? conv_value : 15'sd0;
    end

    assign o_strobe      = r_out_valid;
    assign o_crc_ok      = r_crc_ok;
    assign o_is_humidity = r_is_hum;
    assign o_value_centi = r_value;
    assign o_raw_code    = r_raw;

endmodule

/* rtl/htfd_crc.sv */
// Two-stage CRC-8 check of the data bytes against the check byte.
module htfd_crc #(
    parameter int FRAME_BYTES = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [7:0]        i_poly,
    input  logic [7:0]        i_high_byte,
    input  logic [7:0]        i_low_byte,
    input  logic [7:0]        i_check_byte,
    output htfd_pkg::t_crc_res o_res
);

    logic        r_s1_valid;
    logic [7:0]  r_s1_crc;
    logic [15:0] r_s1_code;
    logic [7:0]  r_s1_chk;

    htfd_pkg::t_crc_res r_s2;

    logic [7:0]  n_s1_crc;
    logic [7:0]  n_s2_crc;
    logic        n_s2_ok;

    assign n_s1_crc = htfd_pkg::crc8_byte(htfd_pkg::CRC_INIT, i_high_byte, i_poly);

    // A one-byte frame covers the high byte only.
    assign n_s2_crc = (FRAME_BYTES >= 2)
                    ? htfd_pkg::crc8_byte(r_s1_crc, r_s1_code[7:0], i_poly)
                    : r_s1_crc;
    assign n_s2_ok  = (n_s2_crc == r_s1_chk);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_valid;
        end
        r_s1_crc  <= n_s1_crc;
        r_s1_code <= {i_high_byte, i_low_byte};
        r_s1_chk  <= i_check_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2.valid <= 1'b0;
        end else begin
            r_s2.valid <= r_s1_valid;
        end
        r_s2.crc_ok   <= n_s2_ok;
        r_s2.is_hum   <= r_s1_code[1];
        r_s2.raw_code <= {r_s1_code[15:2], 2'b00};
    end

    assign o_res = r_s2;

endmodule

/* rtl/htfd_conv.sv */
// Two-stage fixed-point conversion of the status-free code to hundredths.
module htfd_conv (
    input  logic               i_clk,
    input  logic [15:0]        i_code,
    output logic signed [14:0] o_value
);

    logic [30:0]        r_prod;
    logic               r_hum;
    logic signed [14:0] r_value;

    logic [15:0]        n_s;
    logic [14:0]        n_scale;
    logic [30:0]        n_prod;
    logic signed [15:0] n_offset;
    logic signed [15:0] n_sum;

    assign n_s     = {i_code[15:2], 2'b00};
    assign n_scale = i_code[1] ? htfd_pkg::RH_SCALE : htfd_pkg::T_SCALE;
    // Both operands are widened so the full 31-bit product is kept.
    assign n_prod  = {15'd0, n_s} * {16'd0, n_scale};

    // The code is never negative, so the floor is the upper product bits.
    assign n_offset = r_hum ? htfd_pkg::RH_OFFSET : htfd_pkg::T_OFFSET;
    assign n_sum    = n_offset + $signed({1'b0, r_prod[30:16]});

    always_ff @(posedge i_clk) begin
        r_prod  <= n_prod;
        r_hum   <= i_code[1];
        r_value <= n_sum[14:0];
    end

    assign o_value = r_value;

endmodule

/* rtl/htfd_checker.sv */
// Port-level checker for the frame decoder and its bind statement.
`include "humidity_temp_frame_decoder_defines.svh"

module htfd_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic               o_strobe,
    input logic               o_crc_ok,
    input logic               o_is_humidity,
    input logic signed [14:0] o_value_centi,
    input logic [15:0]        o_raw_code
);

    // Every accepted beat leads to a result beat.
    `HTFD_ASSERT_AFTER3(a_beat_to_result, i_clk, i_rst_n, start && !busy, o_strobe)

    // No result beat appears without a frame taken before it.
    `HTFD_ASSERT_IMPLIES(a_no_phantom, i_clk, i_rst_n, o_strobe, $past(start && !busy, 3))

    `HTFD_ASSERT_IMPLIES(a_err_zero, i_clk, i_rst_n, o_strobe && !o_crc_ok, o_value_centi == 15'sd0)

    `HTFD_ASSERT_IMPLIES(a_hum_floor, i_clk, i_rst_n, o_strobe && o_crc_ok && o_is_humidity, o_value_centi >= -15'sd600)

    `HTFD_ASSERT_IMPLIES(a_status_clear, i_clk, i_rst_n, o_strobe, o_raw_code[1:0] == 2'b00)

endmodule

bind humidity_temp_frame_decoder htfd_checker u_htfd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_strobe      (o_strobe),
    .o_crc_ok      (o_crc_ok),
    .o_is_humidity (o_is_humidity),
    .o_value_centi (o_value_centi),
    .o_raw_code    (o_raw_code)
);

/* verif/tb_top.sv */
// Self-checking testbench for the humidity and temperature frame decoder.
module tb_top;

    localparam int PIPE_DEPTH    = 3;
    localparam int RANDOM_FRAMES = 1500;
    localparam int DRAIN_LIMIT   = 400;

    // Conversion constants in hundredths; the spans are scaled by 2^16.
    localparam int          RH_BASE = -600;
    localparam int          T_BASE  = -4685;
    localparam logic [31:0] RH_SPAN = 32'd12500;
    localparam logic [31:0] T_SPAN  = 32'd17572;

    typedef struct packed {
        logic               crc_ok;
        logic               is_humidity;
        logic signed [14:0] value_centi;
        logic [15:0]        raw_code;
    } t_reading;

    logic               i_clk;
    logic               i_rst_n      = 1'b0;
    logic               start        = 1'b0;
    logic [7:0]         i_high_byte  = 8'h00;
    logic [7:0]         i_low_byte   = 8'h00;
    logic [7:0]         i_check_byte = 8'h00;
    logic               i_cfg_we     = 1'b0;
    logic [7:0]         i_cfg_wdata  = 8'h00;
    logic               busy;
    logic               o_strobe;
    logic               o_crc_ok;
    logic               o_is_humidity;
    logic signed [14:0] o_value_centi;
    logic [15:0]        o_raw_code;

    logic [7:0] model_poly = htfd_pkg::POLY_RESET;
    t_reading   expected_readings[$];
    int         frames_sent      = 0;
    int         bad_frames_sent  = 0;
    int         readings_checked = 0;
    int         polys_loaded     = 0;
    int         failures         = 0;

    humidity_temp_frame_decoder uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_high_byte   (i_high_byte),
        .i_low_byte    (i_low_byte),
        .i_check_byte  (i_check_byte),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_strobe      (o_strobe),
        .o_crc_ok      (o_crc_ok),
        .o_is_humidity (o_is_humidity),
        .o_value_centi (o_value_centi),
        .o_raw_code    (o_raw_code)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Bit-serial form of the MSB-first CRC-8 over both data bytes.
    function automatic logic [7:0] frame_crc(input logic [7:0] hi, input logic [7:0] lo);
        logic [15:0] bits;
        logic [7:0]  crc;
        logic        feedback;
        bits = {hi, lo};
        crc  = 8'h00;
        for (int i = 15; i >= 0; i--) begin
            feedback = crc[7] ^ bits[i];
            crc      = {crc[6:0], 1'b0} ^ (feedback ? model_poly : 8'h00);
        end
        return crc;
    endfunction

    function automatic t_reading decode_frame(input logic [7:0] hi, input logic [7:0] lo,
                                              input logic [7:0] chk);
        t_reading    r;
        logic [15:0] code;
        logic [31:0] scaled;
        int          centi;
        code          = {hi, lo};
        r.crc_ok      = (frame_crc(hi, lo) == chk);
        r.is_humidity = code[1];
        r.raw_code    = {code[15:2], 2'b00};
        scaled        = (r.is_humidity ? RH_SPAN : T_SPAN) * {16'h0000, r.raw_code};
        centi         = (r.is_humidity ? RH_BASE : T_BASE) + int'(scaled >> 16);
        r.value_centi = r.crc_ok ? centi[14:0] : 15'sd0;
        return r;
    endfunction

    // Start stays high on return, so back-to-back frames need no extra step.
    task automatic send_frame(input logic [7:0] hi, input logic [7:0] lo,
                              input logic [7:0] chk);
        t_reading want;
        start        <= 1'b1;
        i_high_byte  <= hi;
        i_low_byte   <= lo;
        i_check_byte <= chk;
        do @(posedge i_clk); while (busy !== 1'b0);
        want = decode_frame(hi, lo, chk);
        expected_readings.push_back(want);
        frames_sent++;
        if (!want.crc_ok)
            bad_frames_sent++;
    endtask

    task automatic send_good(input logic [7:0] hi, input logic [7:0] lo);
        send_frame(hi, lo, frame_crc(hi, lo));
    endtask

    // Each cycle is idle with the given chance, so pct is the idle share of cycles.
    task automatic sender_gap(input int pct);
        while ($urandom_range(99) < pct) begin
            start        <= 1'b0;
            i_high_byte  <= 8'($urandom);
            i_low_byte   <= 8'($urandom);
            i_check_byte <= 8'($urandom);
            @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        for (int n = 0; n < DRAIN_LIMIT && expected_readings.size() != 0; n++)
            @(posedge i_clk);
        repeat (PIPE_DEPTH + 2) @(posedge i_clk);
    endtask

    task automatic load_polynomial(input logic [7:0] poly);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= poly;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= 8'($urandom);
        model_poly = poly;
        polys_loaded++;
    endtask

    // Mostly frames with a valid check byte, the rest corrupted or random.
    task automatic random_frame();
        logic [7:0] hi;
        logic [7:0] lo;
        logic [7:0] chk;
        int         roll;
        hi   = ($urandom_range(9) == 0) ? 8'hFF : 8'($urandom);
        lo   = ($urandom_range(9) == 0) ? 8'h00 : 8'($urandom);
        roll = $urandom_range(99);
        if (roll < 75)
            chk = frame_crc(hi, lo);
        else if (roll < 88)
            chk = frame_crc(hi, lo) ^ (8'h01 << $urandom_range(7));
        else
            chk = 8'($urandom);
        send_frame(hi, lo, chk);
    endtask

    task automatic test_default_polynomial();
        send_good(8'h00, 8'h00);   // temperature at the lowest code
        send_good(8'h00, 8'h02);   // humidity at the lowest code
        send_good(8'hFF, 8'hFC);   // temperature at the highest code
        send_good(8'hFF, 8'hFE);   // humidity at the highest code
        send_good(8'hFF, 8'hFF);   // both status bits set
        send_good(8'h00, 8'h01);
        send_good(8'h80, 8'h00);
        send_good(8'h7F, 8'hFD);
        send_good(8'h55, 8'hAA);
        send_good(8'hAA, 8'h57);
        send_frame(8'hFF, 8'hFF, 8'h00);
        send_frame(8'h00, 8'h00, 8'hFF);
        send_frame(8'hFF, 8'hFE, frame_crc(8'hFF, 8'hFE) ^ 8'h80);
    endtask

    task automatic test_polynomial_extremes();
        logic [7:0] polys[4] = '{8'h00, 8'hFF, 8'h80, 8'h07};
        foreach (polys[i]) begin
            load_polynomial(polys[i]);
            send_good(8'($urandom), 8'($urandom));
            send_good(8'hFF, 8'hFF);
            send_frame(8'($urandom), 8'($urandom), 8'($urandom));
        end
    endtask

    task automatic test_random_frames();
        int gap_pct[3] = '{0, 53, 14};
        for (int p = 0; p < 3; p++) begin
            load_polynomial((p == 2) ? htfd_pkg::POLY_RESET : 8'($urandom));
            for (int k = 0; k < RANDOM_FRAMES / 3; k++) begin
                random_frame();
                sender_gap(gap_pct[p]);
                // Let the pipeline run dry once per phase.
                if (k == RANDOM_FRAMES / 6)
                    wait_drained();
            end
        end
    endtask

    always @(posedge i_clk) begin : check_readings
        t_reading want;
        if (i_rst_n === 1'b1) begin
            if (o_strobe === 1'b1) begin
                if (expected_readings.size() == 0) begin
                    $error("result beat with no frame pending");
                    failures++;
                end else begin
                    want = expected_readings.pop_front();
                    readings_checked++;
                    if (o_crc_ok !== want.crc_ok) begin
                        $error("crc_ok: expected %0d, actual %0d", want.crc_ok, o_crc_ok);
                        failures++;
                    end
                    if (o_is_humidity !== want.is_humidity) begin
                        $error("is_humidity: expected %0d, actual %0d",
                               want.is_humidity, o_is_humidity);
                        failures++;
                    end
                    if (o_value_centi !== want.value_centi) begin
                        $error("value_centi: expected %0d, actual %0d",
                               $signed(want.value_centi), $signed(o_value_centi));
                        failures++;
                    end
                    if (o_raw_code !== want.raw_code) begin
                        $error("raw_code: expected 0x%04h, actual 0x%04h",
                               want.raw_code, o_raw_code);
                        failures++;
                    end
                end
            end else if (o_strobe !== 1'b0) begin
                $error("strobe is unknown");
                failures++;
            end
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_default_polynomial();
        test_polynomial_extremes();
        test_random_frames();
        wait_drained();
        if (expected_readings.size() != 0) begin
            $error("%0d readings never arrived", expected_readings.size());
            failures++;
        end
        $display("Sent %0d frames (%0d with a bad check byte) under %0d polynomial loads,",
                 frames_sent, bad_frames_sent, polys_loaded);
        $display("and compared %0d readings of both kinds with and without sender gaps.",
                 readings_checked);
        if (failures == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/htfd_pkg.sv
rtl/htfd_crc.sv
rtl/htfd_conv.sv
rtl/humidity_temp_frame_decoder.sv
rtl/htfd_checker.sv
verif/tb_top.sv
